>>> rtl/core/smsd_pkg.sv
`timescale 1ns / 1ps

package smsd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CAP_W     = 11;
  localparam int COUNT_W   = 11;
  localparam int MEAN_W    = 24;
  localparam int STD_W     = 23;
  localparam int FRAC_W    = 8;
  localparam int VAR_SHIFT = 2 * FRAC_W;
  localparam int MEAN_QW   = 24;
  localparam int VAR_QW    = 47;
  localparam int ROOT_W    = 24;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef struct packed {
    logic capture;
    logic square;
    logic update;
    logic prep;
    logic start;
    logic sub;
    logic start_var;
    logic start_sqrt;
    logic load_out;
  } smsd_cmd_t;

  typedef struct packed {
    logic empty;
    logic mul_busy;
    logic mdiv_busy;
    logic vdiv_busy;
    logic sqrt_busy;
  } smsd_sts_t;

endpackage

>>> rtl/core/sample_mean_stddev_accumulator.sv
`timescale 1ns / 1ps

// Running mean and population standard deviation of signed 16-bit samples.
// Each sample transfer yields one result: whether the sample was taken (it
// is taken while the count is below the lesser of the capacity register and
// MAX_CAPACITY), the count, the mean and the standard deviation, both in
// fixed point with 8 fraction bits, truncated, and zero while nothing has
// been taken. One sample is processed at a time: the controller steps
// through capture, square, update, the bit-serial multiply of count by the
// square sum, the one-bit-per-cycle variance divider and the
// one-bit-per-cycle square root, with the mean divider running alongside,
// and the next sample can be taken in the cycle after its result is loaded.
// While the count is zero the multiply, divide and root steps are skipped.
// A finished result waits in an output register while the next sample is
// taken; that sample's result is held back until the earlier one has been
// transferred. Capacity writes are taken in any cycle and belong only
// between items.

module sample_mean_stddev_accumulator #(
  parameter int MAX_CAPACITY = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [smsd_pkg::SAMPLE_W-1:0] sample,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic                                 accepted,
  output logic        [smsd_pkg::COUNT_W-1:0]  count,
  output logic signed [smsd_pkg::MEAN_W-1:0]   mean,
  output logic        [smsd_pkg::STD_W-1:0]    std_dev,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [smsd_pkg::CAP_W-1:0]    cfg_data
);

  import smsd_pkg::*;

  smsd_cmd_t cmd;
  smsd_sts_t sts;

  assign cfg_ready = 1'b1;

  smsd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  smsd_datapath #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .accepted (accepted),
    .count    (count),
    .mean     (mean),
    .std_dev  (std_dev)
  );

endmodule

>>> rtl/core/smsd_div.sv
`timescale 1ns / 1ps

module smsd_div #(
  parameter int XW = 33,
  parameter int DW = 11,
  parameter int QW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [XW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [QW-1:0] quotient
);

  localparam int CNTW = $clog2(QW + 1);

  logic [DW-1:0]   rem;
  logic [QW-1:0]   low;
  logic [CNTW-1:0] cnt;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;

  assign trial = {rem, low[QW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(QW);
    end else if (busy) begin
      busy <= (cnt != CNTW'(1));
      cnt  <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DW'(dividend >> QW);
      low <= dividend[QW-1:0];
    end else if (busy) begin
      rem      <= ge ? diff[DW-1:0] : trial[DW-1:0];
      low      <= {low[QW-2:0], 1'b0};
      quotient <= {quotient[QW-2:0], ge};
    end
  end

endmodule

>>> rtl/core/smsd_sqrt.sv
`timescale 1ns / 1ps

module smsd_sqrt #(
  parameter int RW = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2*RW-1:0]   radicand,
  output logic              busy,
  output logic [RW-1:0]     root
);

  localparam int CNTW = $clog2(RW + 1);

  logic [2*RW-1:0] rad;
  logic [RW:0]     rem;
  logic [CNTW-1:0] cnt;
  logic [RW+2:0]   part;
  logic [RW+2:0]   trial;
  logic [RW+2:0]   diff;
  logic            ge;

  assign part  = {rem, rad[2*RW-1:2*RW-2]};
  assign trial = {1'b0, root, 2'b01};
  assign diff  = part - trial;
  assign ge    = part >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(RW);
    end else if (busy) begin
      busy <= (cnt != CNTW'(1));
      cnt  <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[2*RW-3:0], 2'b00};
      rem  <= ge ? diff[RW:0] : part[RW:0];
      root <= {root[RW-2:0], ge};
    end
  end

endmodule

>>> rtl/core/smsd_datapath.sv
`timescale 1ns / 1ps

module smsd_datapath #(
  parameter int MAX_CAPACITY = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [smsd_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 cfg_valid,
  input  logic        [smsd_pkg::CAP_W-1:0]    cfg_data,
  input  smsd_pkg::smsd_cmd_t                  cmd,
  output smsd_pkg::smsd_sts_t                  sts,
  output logic                                 accepted,
  output logic        [smsd_pkg::COUNT_W-1:0]  count,
  output logic signed [smsd_pkg::MEAN_W-1:0]   mean,
  output logic        [smsd_pkg::STD_W-1:0]    std_dev
);

  import smsd_pkg::*;

  localparam int CW    = $clog2(MAX_CAPACITY + 1);
  localparam int SUMW  = SAMPLE_W + CW;
  localparam int MAGW  = SUMW - 1;
  localparam int SQ1W  = 2 * SAMPLE_W - 1;
  localparam int SQW   = SQ1W - 1 + CW;
  localparam int PRODW = SQW + CW;
  localparam int NNW   = 2 * CW;
  localparam int MXW   = MAGW + FRAC_W;
  localparam int VXW   = PRODW + VAR_SHIFT;
  localparam int RADW  = 2 * ROOT_W;
  localparam int CMPW  = ((CW > CAP_W) ? CW : CAP_W) + 1;
  localparam int MCNTW = $clog2(CW + 1);

  logic        [CAP_W-1:0]      capacity;
  logic signed [SAMPLE_W-1:0]   samp;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic        [SQ1W-1:0]       sq;
  logic                         acc_flag;
  logic                         acc_ok;
  logic        [CW-1:0]         cnt;
  logic signed [SUMW-1:0]       sum;
  logic        [SUMW-1:0]       sum_abs;
  logic        [SQW-1:0]        sumsq;
  logic        [MAGW-1:0]       mag;
  logic                         neg;
  logic                         empty;
  logic        [PRODW-1:0]      sum2;
  logic        [NNW-1:0]        nn;
  logic        [PRODW-1:0]      dvar;
  logic        [PRODW-1:0]      prod;
  logic        [PRODW-1:0]      mcand;
  logic        [CW-1:0]         mplier;
  logic        [MCNTW-1:0]      mcnt;
  logic                         mul_busy;
  logic        [MEAN_QW-1:0]    mq;
  logic        [MEAN_W-1:0]     mean_mag;
  logic        [VAR_QW-1:0]     vq;
  logic        [ROOT_W-1:0]     root;
  logic                         mdiv_busy;
  logic                         vdiv_busy;
  logic                         sqrt_busy;

  assign acc_ok  = (CMPW'(cnt) < CMPW'(capacity)) && (CMPW'(cnt) < CMPW'(MAX_CAPACITY));
  assign sq_full = samp * samp;
  assign sum_abs = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
  assign mean_mag = MEAN_W'(mq);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      cnt      <= '0;
      sum      <= '0;
      sumsq    <= '0;
      mul_busy <= 1'b0;
      mcnt     <= '0;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      if (cmd.update && acc_flag) begin
        cnt   <= cnt + 1'b1;
        sum   <= sum + {{(SUMW-SAMPLE_W){samp[SAMPLE_W-1]}}, samp};
        sumsq <= sumsq + SQW'(sq);
      end
      if (cmd.start) begin
        mul_busy <= 1'b1;
        mcnt     <= MCNTW'(CW);
      end else if (mul_busy) begin
        mul_busy <= (mcnt != MCNTW'(1));
        mcnt     <= mcnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      samp     <= sample;
      acc_flag <= acc_ok;
    end
    if (cmd.square) begin
      sq <= sq_full[SQ1W-1:0];
    end
    if (cmd.prep) begin
      mag   <= sum_abs[MAGW-1:0];
      neg   <= sum[SUMW-1];
      empty <= (cnt == '0);
    end
    if (cmd.start) begin
      sum2   <= mag * mag;
      nn     <= cnt * cnt;
      prod   <= '0;
      mcand  <= PRODW'(sumsq);
      mplier <= cnt;
    end else if (mul_busy) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= {mcand[PRODW-2:0], 1'b0};
      mplier <= mplier >> 1;
    end
    if (cmd.sub) begin
      dvar <= (prod >= sum2) ? (prod - sum2) : '0;
    end
    if (cmd.load_out) begin
      accepted <= acc_flag;
      count    <= COUNT_W'(cnt);
      mean     <= empty ? '0 : (neg ? MEAN_W'(-mean_mag) : mean_mag);
      std_dev  <= empty ? '0 : root[STD_W-1:0];
    end
  end

  smsd_div #(
    .XW(MXW),
    .DW(CW),
    .QW(MEAN_QW)
  ) u_mean_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.start),
    .dividend({mag, {FRAC_W{1'b0}}}),
    .divisor (cnt),
    .busy    (mdiv_busy),
    .quotient(mq)
  );

  smsd_div #(
    .XW(VXW),
    .DW(NNW),
    .QW(VAR_QW)
  ) u_var_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.start_var),
    .dividend({dvar, {VAR_SHIFT{1'b0}}}),
    .divisor (nn),
    .busy    (vdiv_busy),
    .quotient(vq)
  );

  smsd_sqrt #(
    .RW(ROOT_W)
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.start_sqrt),
    .radicand(RADW'(vq)),
    .busy    (sqrt_busy),
    .root    (root)
  );

  assign sts.empty     = empty;
  assign sts.mul_busy  = mul_busy;
  assign sts.mdiv_busy = mdiv_busy;
  assign sts.vdiv_busy = vdiv_busy;
  assign sts.sqrt_busy = sqrt_busy;

endmodule

>>> rtl/core/smsd_ctrl.sv
`timescale 1ns / 1ps

module smsd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  output logic                result_valid,
  input  logic                result_stall,
  input  smsd_pkg::smsd_sts_t sts,
  output smsd_pkg::smsd_cmd_t cmd
);

  import smsd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQUARE,
    S_UPDATE,
    S_PREP,
    S_START,
    S_MUL,
    S_SUB,
    S_VSTART,
    S_VDIV,
    S_SQSTART,
    S_SQRT,
    S_OUT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free     = !result_valid || !result_stall;
  assign sample_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.capture    = (state == S_IDLE) && sample_valid;
    cmd.square     = (state == S_SQUARE);
    cmd.update     = (state == S_UPDATE);
    cmd.prep       = (state == S_PREP);
    cmd.start      = (state == S_START) && !sts.empty;
    cmd.sub        = (state == S_SUB);
    cmd.start_var  = (state == S_VSTART);
    cmd.start_sqrt = (state == S_SQSTART);
    cmd.load_out   = (state == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if ((state == S_OUT) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            state <= S_SQUARE;
          end
        end
        S_SQUARE:  state <= S_UPDATE;
        S_UPDATE:  state <= S_PREP;
        S_PREP:    state <= S_START;
        S_START:   state <= sts.empty ? S_OUT : S_MUL;
        S_MUL: begin
          if (!sts.mul_busy) begin
            state <= S_SUB;
          end
        end
        S_SUB:     state <= S_VSTART;
        S_VSTART:  state <= S_VDIV;
        S_VDIV: begin
          if (!sts.vdiv_busy) begin
            state <= S_SQSTART;
          end
        end
        S_SQSTART: state <= S_SQRT;
        S_SQRT: begin
          if (!sts.sqrt_busy && !sts.mdiv_busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default:   state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> bench/sample_mean_stddev_accumulator_tb.sv
`timescale 1ns / 1ps

module sample_mean_stddev_accumulator_tb;
  import smsd_pkg::*;

  localparam int MAX_CAP = 1024;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic               accepted;
    logic [COUNT_W-1:0] count;
    logic [MEAN_W-1:0]  mean;
    logic [STD_W-1:0]   std_dev;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic accepted;
  logic [COUNT_W-1:0] count;
  logic signed [MEAN_W-1:0] mean;
  logic [STD_W-1:0] std_dev;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  sample_mean_stddev_accumulator #(
    .MAX_CAPACITY(MAX_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .accepted(accepted),
    .count(count),
    .mean(mean),
    .std_dev(std_dev),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [CAP_W-1:0] capacity_setting = CAP_RESET;
  longint unsigned acc_count = 0;
  longint acc_sum = 0;
  longint unsigned acc_sqsum = 0;

  stats_t expected_stats_q[$];
  int mismatch_count = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int samples_taken = 0;
  int capacity_writes = 0;
  bit sender_no_idle = 1'b0;
  bit receiver_no_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] last_sample = '0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 25; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic stats_t accumulate_sample(logic signed [SAMPLE_W-1:0] s);
    stats_t r;
    longint sv;
    longint unsigned eff_cap, n, mag, mq, sum2, prod, d, nn, q, root;
    longint unsigned mean_full;
    r = '0;
    sv = s;
    eff_cap = (capacity_setting > MAX_CAP) ? MAX_CAP : capacity_setting;
    if (acc_count < eff_cap) begin
      acc_count++;
      acc_sum += sv;
      acc_sqsum += longint'(sv * sv);
      r.accepted = 1'b1;
    end
    if (acc_count != 0) begin
      n = acc_count;
      mag = (acc_sum < 0) ? longint'(-acc_sum) : longint'(acc_sum);
      mq = (mag * 256) / n;
      sum2 = mag * mag;
      prod = n * acc_sqsum;
      d = (prod >= sum2) ? prod - sum2 : 0;
      nn = n * n;
      q = (d / nn) * 65536 + ((d % nn) * 65536) / nn;
      mean_full = (acc_sum < 0) ? 64'd0 - mq : mq;
      root = int_sqrt(q);
      r.mean = mean_full[MEAN_W-1:0];
      r.std_dev = root[STD_W-1:0];
    end
    r.count = acc_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'sh7fff;
      1: v = 16'sh8000;
      2, 3: v = $signed(16'($urandom_range(0, 16))) - 16'sd8;
      4: v = last_sample;
      default: v = 16'($urandom);
    endcase
    last_sample = v;
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("MISMATCH %s: got %0h expected %0h (result %0d)",
               what, got, want, results_checked);
  endtask

  task automatic send_sample(logic signed [SAMPLE_W-1:0] value);
    int gap;
    stats_t predicted;
    gap = sender_no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= value;
    @(posedge clk);
    while (sample_stall !== 1'b0) @(posedge clk);
    predicted = accumulate_sample(value);
    expected_stats_q.push_back(predicted);
    samples_sent++;
    if (predicted.accepted) samples_taken++;
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    sample_valid <= 1'b0;
    while (expected_stats_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(int value);
    cfg_valid <= 1'b1;
    cfg_data <= CAP_W'(value);
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    capacity_setting = CAP_W'(value);
    capacity_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_empty_accumulator();
    hold_until_drained();
    write_capacity(0);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
  endtask

  task automatic test_field_extremes();
    logic signed [SAMPLE_W-1:0] vals[10];
    vals = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0000,
             16'shffff, 16'sh0001, 16'sh5555, 16'shaaaa, 16'sh8000};
    hold_until_drained();
    write_capacity(2047);
    foreach (vals[i]) send_sample(vals[i]);
  endtask

  task automatic test_capacity_limits();
    hold_until_drained();
    write_capacity(int'(acc_count) - 3);
    repeat (3) send_sample(draw_sample());
    hold_until_drained();
    write_capacity(int'(acc_count) + 2);
    repeat (4) send_sample(draw_sample());
  endtask

  task automatic test_sender_pause();
    hold_until_drained();
    write_capacity(MAX_CAP);
    sender_no_idle = 1'b1;
    repeat (20) send_sample(draw_sample());
    hold_until_drained();
    repeat (20) send_sample(draw_sample());
    sender_no_idle = 1'b0;
  endtask

  task automatic test_random_samples(int cap_value, int n_items);
    hold_until_drained();
    write_capacity(cap_value);
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        sender_no_idle = ($urandom_range(0, 3) == 0);
        receiver_no_stall = ($urandom_range(0, 3) == 0);
      end
      send_sample(draw_sample());
    end
  endtask

  // result side: at times stall while a result waits, then take it and compare
  initial begin : result_checker
    int gap;
    stats_t want;
    @(negedge rst);
    forever begin
      gap = receiver_no_stall ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        result_stall <= 1'b1;
        @(posedge clk);
        while (result_valid !== 1'b1) @(posedge clk);
        repeat (gap) @(negedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (result_valid !== 1'b1) @(posedge clk);
      if (expected_stats_q.size() == 0) begin
        report_mismatch("unexpected result", {21'b0, count}, 32'd0);
      end else begin
        want = expected_stats_q.pop_front();
        if (accepted !== want.accepted)
          report_mismatch("accepted", {31'b0, accepted}, {31'b0, want.accepted});
        if (count !== want.count)
          report_mismatch("count", {21'b0, count}, {21'b0, want.count});
        if (mean !== want.mean)
          report_mismatch("mean", {8'b0, mean}, {8'b0, want.mean});
        if (std_dev !== want.std_dev)
          report_mismatch("std_dev", {9'b0, std_dev}, {9'b0, want.std_dev});
      end
      results_checked++;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_accumulator();
    test_field_extremes();
    test_capacity_limits();
    test_sender_pause();
    test_random_samples(int'(acc_count) + 150, 300);
    test_random_samples(int'(acc_count) + 250, 250);
    test_random_samples(MAX_CAP, 350);
    test_random_samples(2047, 300);
    test_random_samples(1, 300);

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d samples (%0d taken, %0d rejected), %0d results checked",
             samples_sent, samples_taken, samples_sent - samples_taken, results_checked);
    $display("Capacity written %0d times, final count %0d, %0d mismatches",
             capacity_writes, acc_count, mismatch_count);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
